@@ sv/trd_pkg.sv @@
// trd_pkg: shared types and byte codes for the terminal reply decoder.
// No dependencies; used by trd_parser, terminal_reply_decoder and the bench.
`timescale 1ns / 1ps

package trd_pkg;

   localparam logic [7:0] CH_LBRACKET = 8'h5B;  // '['
   localparam logic [7:0] CH_QUERY    = 8'h3F;  // '?'
   localparam logic [7:0] CH_SIX      = 8'h36;  // '6'
   localparam logic [7:0] CH_SEMI     = 8'h3B;  // ';'
   localparam logic [7:0] CH_UPPER_G  = 8'h47;  // 'G'
   localparam logic [7:0] CH_LOWER_I  = 8'h69;  // 'i'
   localparam logic [7:0] CH_EQUAL    = 8'h3D;  // '='
   localparam logic [7:0] CH_GREATER  = 8'h3E;  // '>'
   localparam logic [7:0] CH_LOWER_C  = 8'h63;  // 'c'
   localparam logic [7:0] CH_LOWER_T  = 8'h74;  // 't'
   localparam logic [7:0] CH_LPAREN   = 8'h28;  // '('
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_DOT      = 8'h2E;  // '.'
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;

   localparam int unsigned SIXEL_ATTR   = 4;
   localparam int unsigned ACK_IMAGE_ID = 31;
   localparam int unsigned MIN_MINOR    = 28;

   // Bytes of the version tag after its leading '>', indexed from 0.
   function automatic logic [7:0] ver_tag_byte(input logic [2:0] idx);
      logic [7:0] code;
      case (idx)
         3'd0:    code = 8'h7C;
         3'd1:    code = 8'h6B;
         3'd2:    code = 8'h69;
         3'd3:    code = 8'h74;
         3'd4:    code = 8'h74;
         3'd5:    code = 8'h79;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   typedef struct packed {
      logic        recognized;
      logic        sixel_support;
      logic        image_ack_support;
      logic        placeholder_support;
      logic [15:0] cell_width_px;
      logic [15:0] cell_height_px;
   } result_type;

endpackage

@@ sv/trd_parser.sv @@
// trd_parser: per-byte reply grammar, sticky support flags and cell size.
// Depends on trd_pkg. Result is the profile as it stands after the given byte.
`timescale 1ns / 1ps

module trd_parser #(
   parameter int CELL_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          reply_byte,
   input  logic                payload_end,
   output trd_pkg::result_type result
);
   import trd_pkg::*;

   typedef enum logic [4:0] {
      PH_START, PH_LB, PH_CS_SEMI, PH_G1, PH_G2,
      PH_V1, PH_V2, PH_V3, PH_V4, PH_V5, PH_V6,
      PH_DA_FIELD, PH_DA_SKIP, PH_CS_H, PH_CS_W, PH_KI_ID,
      PH_VER_OPT, PH_VER_MAJ, PH_VER_MIN, PH_DONE
   } phase_type;

   localparam logic [CELL_BITS+3:0] SAT_MAX = {4'd0, {CELL_BITS{1'b1}}};

   phase_type            phase_ff, phase_in;
   logic [CELL_BITS-1:0] accum_ff, accum_in;
   logic                 digits_ff, digits_in;
   logic [CELL_BITS-1:0] held_ff, held_in;
   logic                 major_ff, major_in;
   logic                 match_ff, match_in;
   logic                 sixel_ff, sixel_in;
   logic                 ack_ff, ack_in;
   logic                 place_ff, place_in;
   logic [CELL_BITS-1:0] width_ff, width_in;
   logic [CELL_BITS-1:0] height_ff, height_in;

   logic                 is_digit;
   logic [CELL_BITS+3:0] acc_times10;
   logic [CELL_BITS-1:0] acc_digit;
   logic [2:0]           tag_idx;
   logic [31:0]          width_wide;
   logic [31:0]          height_wide;

   assign is_digit    = (reply_byte >= CH_ZERO) && (reply_byte <= CH_NINE);
   assign acc_times10 = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1)
                        + (CELL_BITS+4)'(reply_byte[3:0]);
   assign acc_digit   = (acc_times10 > SAT_MAX) ? {CELL_BITS{1'b1}}
                                                : acc_times10[CELL_BITS-1:0];
   assign tag_idx     = 3'(phase_ff - PH_V1);

   always_comb begin
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      digits_in = digits_ff;
      held_in   = held_ff;
      major_in  = major_ff;
      match_in  = match_ff;
      sixel_in  = sixel_ff;
      ack_in    = ack_ff;
      place_in  = place_ff;
      width_in  = width_ff;
      height_in = height_ff;

      case (phase_ff)
         PH_START: begin
            if (reply_byte == CH_LBRACKET)     phase_in = PH_LB;
            else if (reply_byte == CH_UPPER_G) phase_in = PH_G1;
            else if (reply_byte == CH_GREATER) phase_in = PH_V1;
            else                               phase_in = PH_DONE;
         end
         PH_LB: begin
            if (reply_byte == CH_QUERY) begin
               match_in  = 1'b1;
               phase_in  = PH_DA_FIELD;
               accum_in  = '0;
               digits_in = 1'b0;
            end else if (reply_byte == CH_SIX) begin
               phase_in = PH_CS_SEMI;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_CS_SEMI: begin
            if (reply_byte == CH_SEMI) begin
               phase_in  = PH_CS_H;
               accum_in  = '0;
               digits_in = 1'b0;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_G1: phase_in = (reply_byte == CH_LOWER_I) ? PH_G2 : PH_DONE;
         PH_G2: begin
            if (reply_byte == CH_EQUAL) begin
               match_in  = 1'b1;
               phase_in  = PH_KI_ID;
               accum_in  = '0;
               digits_in = 1'b0;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_V1, PH_V2, PH_V3, PH_V4, PH_V5, PH_V6: begin
            if (reply_byte != ver_tag_byte(tag_idx)) begin
               phase_in = PH_DONE;
            end else if (phase_ff == PH_V6) begin
               match_in  = 1'b1;
               phase_in  = PH_VER_OPT;
               accum_in  = '0;
               digits_in = 1'b0;
            end else begin
               phase_in = phase_type'(phase_ff + 5'd1);
            end
         end
         PH_DA_FIELD, PH_DA_SKIP: begin
            if (phase_ff == PH_DA_FIELD && is_digit) begin
               accum_in  = acc_digit;
               digits_in = 1'b1;
            end else begin
               if (phase_ff == PH_DA_FIELD && digits_ff
                   && accum_ff == CELL_BITS'(SIXEL_ATTR))
                  sixel_in = 1'b1;
               if (reply_byte == CH_SEMI) begin
                  phase_in  = PH_DA_FIELD;
                  accum_in  = '0;
                  digits_in = 1'b0;
               end else if (reply_byte == CH_LOWER_C) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_DA_SKIP;
               end
            end
         end
         PH_CS_H: begin
            if (is_digit) begin
               accum_in  = acc_digit;
               digits_in = 1'b1;
            end else if (reply_byte == CH_SEMI && digits_ff) begin
               held_in   = accum_ff;
               phase_in  = PH_CS_W;
               accum_in  = '0;
               digits_in = 1'b0;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_CS_W: begin
            if (is_digit) begin
               accum_in  = acc_digit;
               digits_in = 1'b1;
            end else begin
               if (reply_byte == CH_LOWER_T && digits_ff) begin
                  match_in = 1'b1;
                  // zero in either dimension leaves the stored size alone
                  if (accum_ff != '0 && held_ff != '0) begin
                     width_in  = accum_ff;
                     height_in = held_ff;
                  end
               end
               phase_in = PH_DONE;
            end
         end
         PH_KI_ID: begin
            if (is_digit) begin
               accum_in  = acc_digit;
               digits_in = 1'b1;
            end else begin
               if (digits_ff && accum_ff == CELL_BITS'(ACK_IMAGE_ID)
                   && reply_byte == CH_SEMI)
                  ack_in = 1'b1;
               phase_in = PH_DONE;
            end
         end
         PH_VER_OPT: begin
            phase_in = PH_VER_MAJ;
            if (is_digit) begin
               accum_in  = acc_digit;
               digits_in = 1'b1;
            end else if (reply_byte != CH_LPAREN && reply_byte != CH_SPACE) begin
               phase_in = PH_DONE;
            end
         end
         PH_VER_MAJ: begin
            if (is_digit) begin
               accum_in  = acc_digit;
               digits_in = 1'b1;
            end else if (reply_byte == CH_DOT && digits_ff) begin
               major_in  = (accum_ff != '0);
               phase_in  = PH_VER_MIN;
               accum_in  = '0;
               digits_in = 1'b0;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_VER_MIN: begin
            if (is_digit) begin
               accum_in  = acc_digit;
               digits_in = 1'b1;
            end else begin
               if (digits_ff && (major_ff || accum_ff >= CELL_BITS'(MIN_MINOR)))
                  place_in = 1'b1;
               phase_in = PH_DONE;
            end
         end
         default: phase_in = PH_DONE;
      endcase

      if (payload_end) begin
         // a field cut off by the payload end is judged here
         if (phase_in == PH_DA_FIELD && digits_in
             && accum_in == CELL_BITS'(SIXEL_ATTR))
            sixel_in = 1'b1;
         if (phase_in == PH_VER_MIN && digits_in
             && (major_in || accum_in >= CELL_BITS'(MIN_MINOR)))
            place_in = 1'b1;
      end
   end

   assign width_wide  = 32'(width_in);
   assign height_wide = 32'(height_in);

   always_comb begin
      result.recognized          = match_in;
      result.sixel_support       = sixel_in;
      result.image_ack_support   = ack_in;
      result.placeholder_support = place_in;
      result.cell_width_px  = (width_wide > 32'h0000_FFFF) ? 16'hFFFF : width_wide[15:0];
      result.cell_height_px = (height_wide > 32'h0000_FFFF) ? 16'hFFFF : height_wide[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         accum_ff  <= '0;
         digits_ff <= 1'b0;
         held_ff   <= '0;
         major_ff  <= 1'b0;
         match_ff  <= 1'b0;
         sixel_ff  <= 1'b0;
         ack_ff    <= 1'b0;
         place_ff  <= 1'b0;
         width_ff  <= '0;
         height_ff <= '0;
      end else if (step) begin
         sixel_ff  <= sixel_in;
         ack_ff    <= ack_in;
         place_ff  <= place_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         if (payload_end) begin
            phase_ff  <= PH_START;
            accum_ff  <= '0;
            digits_ff <= 1'b0;
            held_ff   <= '0;
            major_ff  <= 1'b0;
            match_ff  <= 1'b0;
         end else begin
            phase_ff  <= phase_in;
            accum_ff  <= accum_in;
            digits_ff <= digits_in;
            held_ff   <= held_in;
            major_ff  <= major_in;
            match_ff  <= match_in;
         end
      end
   end

   a_sixel_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(sixel_ff) |-> $past(reset))
      else $error("sixel flag cleared outside reset");

   a_ack_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(ack_ff) |-> $past(reset))
      else $error("image ack flag cleared outside reset");

   a_size_pair: assert property (@(posedge clock) disable iff (reset)
      (width_ff == '0) == (height_ff == '0))
      else $error("cell size stored with only one dimension");

endmodule

@@ sv/terminal_reply_decoder.sv @@
// rsp_tvalid is registered: the last byte is parsed from the input register
// straight into the result register, which raises rsp_tvalid.
// Throughput: one byte per cycle; only a last byte waits, and only while the
// previous result is still not taken.
// Reset (synchronous, active high) clears the profile, the parse state and
// both valid flags; no result is pending after reset.
`timescale 1ns / 1ps

module terminal_reply_decoder #(
   parameter int CELL_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] reply_byte
   input  logic        req_tlast,   // payload_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] sixel_support, [1] image_ack_support,
                                    // [2] placeholder_support, [18:3] cell_width_px,
                                    // [34:19] cell_height_px, [39:35] zero
   output logic        rsp_tuser    // recognized
);
   import trd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type parse_result;
   logic       step;

   // a non-final byte never waits on the result side
   assign step        = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = (step && in_last_ff) ? 1'b1
                                              : (rsp_tready ? 1'b0 : out_valid_ff);

   trd_parser #(
      .CELL_BITS (CELL_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .reply_byte  (in_byte_ff),
      .payload_end (in_last_ff),
      .result      (parse_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && in_last_ff) begin
         out_ff <= parse_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.recognized;
   assign rsp_tdata  = {5'd0, out_ff.cell_height_px, out_ff.cell_width_px,
                        out_ff.placeholder_support, out_ff.image_ack_support,
                        out_ff.sixel_support};

   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_last_ff && out_valid_ff && !rsp_tready |=> in_valid_ff)
      else $error("final byte dropped while result stalled");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(step && in_last_ff))
      else $error("result raised without a final byte");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && in_last_ff && out_valid_ff)
      else $error("input stalled without a blocked final byte");

endmodule

@@ bench/tb_terminal_reply_decoder.sv @@
// tb_terminal_reply_decoder: self-checking bench for terminal_reply_decoder.
// Drives reply payloads byte by byte, predicts each end-of-payload profile
// item in a scoreboard class and checks it field by field. Needs trd_pkg.
`timescale 1ns / 1ps

module tb_terminal_reply_decoder;
   import trd_pkg::*;

   class profile_board;
      typedef enum {
         S_START, S_BRACKET, S_SIZE_SEMI, S_G1, S_G2, S_TAG,
         S_ATTR, S_ATTR_SKIP, S_HEIGHT, S_WIDTH, S_ACK_ID,
         S_VER_OPT, S_VER_MAJ, S_VER_MIN, S_DONE
      } phase_e;

      // sticky profile
      bit          sixel_seen;
      bit          ack_seen;
      bit          placeholder_seen;
      bit [15:0]   width;
      bit [15:0]   height;
      // per-payload scan state
      phase_e      phase;
      bit [2:0]    tag_idx;
      bit [15:0]   accum;
      bit          have_digits;
      bit [15:0]   held_height;
      bit          major_nz;
      bit          matched;

      result_type  profile_q[$];
      int          mismatches;

      function new();
         sixel_seen       = 1'b0;
         ack_seen         = 1'b0;
         placeholder_seen = 1'b0;
         width            = '0;
         height           = '0;
         mismatches       = 0;
         clear_payload();
      endfunction

      function void clear_payload();
         phase       = S_START;
         tag_idx     = '0;
         accum       = '0;
         have_digits = 1'b0;
         held_height = '0;
         major_nz    = 1'b0;
         matched     = 1'b0;
      endfunction

      function void restart_number();
         accum       = '0;
         have_digits = 1'b0;
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= CH_ZERO && b <= CH_NINE;
      endfunction

      // decimal accumulate, saturating at the 16-bit cell range
      function void take_digit(logic [7:0] b);
         int unsigned v;
         v = accum * 10 + (b - CH_ZERO);
         accum = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
         have_digits = 1'b1;
      endfunction

      function void attr_separator(logic [7:0] b);
         if (b == CH_SEMI) begin
            phase = S_ATTR;
            restart_number();
         end else if (b == CH_LOWER_C) begin
            phase = S_DONE;
         end else begin
            phase = S_ATTR_SKIP;
         end
      endfunction

      function void decode_byte(logic [7:0] b);
         case (phase)
            S_START: begin
               if (b == CH_LBRACKET) phase = S_BRACKET;
               else if (b == CH_UPPER_G) phase = S_G1;
               else if (b == CH_GREATER) begin
                  phase   = S_TAG;
                  tag_idx = '0;
               end else phase = S_DONE;
            end
            S_BRACKET: begin
               if (b == CH_QUERY) begin
                  matched = 1'b1;
                  phase   = S_ATTR;
                  restart_number();
               end else if (b == CH_SIX) phase = S_SIZE_SEMI;
               else phase = S_DONE;
            end
            S_SIZE_SEMI: begin
               if (b == CH_SEMI) begin
                  phase = S_HEIGHT;
                  restart_number();
               end else phase = S_DONE;
            end
            S_G1: phase = (b == CH_LOWER_I) ? S_G2 : S_DONE;
            S_G2: begin
               if (b == CH_EQUAL) begin
                  matched = 1'b1;
                  phase   = S_ACK_ID;
                  restart_number();
               end else phase = S_DONE;
            end
            S_TAG: begin
               if (b != ver_tag_byte(tag_idx)) phase = S_DONE;
               else if (tag_idx == 3'd5) begin
                  matched = 1'b1;
                  phase   = S_VER_OPT;
                  restart_number();
               end else tag_idx++;
            end
            S_ATTR: begin
               if (is_digit(b)) take_digit(b);
               else begin
                  if (have_digits && accum == SIXEL_ATTR) sixel_seen = 1'b1;
                  attr_separator(b);
               end
            end
            S_ATTR_SKIP: begin
               if (b == CH_SEMI || b == CH_LOWER_C) attr_separator(b);
            end
            S_HEIGHT: begin
               if (is_digit(b)) take_digit(b);
               else if (b == CH_SEMI && have_digits) begin
                  held_height = accum;
                  phase       = S_WIDTH;
                  restart_number();
               end else phase = S_DONE;
            end
            S_WIDTH: begin
               if (is_digit(b)) take_digit(b);
               else begin
                  if (b == CH_LOWER_T && have_digits) begin
                     matched = 1'b1;
                     // zero in either dimension leaves the stored size alone
                     if (accum != 0 && held_height != 0) begin
                        width  = accum;
                        height = held_height;
                     end
                  end
                  phase = S_DONE;
               end
            end
            S_ACK_ID: begin
               if (is_digit(b)) take_digit(b);
               else begin
                  if (have_digits && accum == ACK_IMAGE_ID && b == CH_SEMI) ack_seen = 1'b1;
                  phase = S_DONE;
               end
            end
            S_VER_OPT: begin
               phase = S_VER_MAJ;
               if (is_digit(b)) take_digit(b);
               else if (b != CH_LPAREN && b != CH_SPACE) phase = S_DONE;
            end
            S_VER_MAJ: begin
               if (is_digit(b)) take_digit(b);
               else if (b == CH_DOT && have_digits) begin
                  major_nz = (accum != 0);
                  phase    = S_VER_MIN;
                  restart_number();
               end else phase = S_DONE;
            end
            S_VER_MIN: begin
               if (is_digit(b)) take_digit(b);
               else begin
                  if (have_digits && (major_nz || accum >= MIN_MINOR)) placeholder_seen = 1'b1;
                  phase = S_DONE;
               end
            end
            default: phase = S_DONE;
         endcase
      endfunction

      // one accepted input item; the last byte of a payload queues a profile
      function void note_byte(logic [7:0] b, logic last);
         result_type r;
         decode_byte(b);
         if (last) begin
            // field still open at the payload end is judged here
            if (phase == S_ATTR && have_digits && accum == SIXEL_ATTR) sixel_seen = 1'b1;
            if (phase == S_VER_MIN && have_digits && (major_nz || accum >= MIN_MINOR))
               placeholder_seen = 1'b1;
            r.recognized          = matched;
            r.sixel_support       = sixel_seen;
            r.image_ack_support   = ack_seen;
            r.placeholder_support = placeholder_seen;
            r.cell_width_px       = width;
            r.cell_height_px      = height;
            profile_q.push_back(r);
            clear_payload();
         end
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_result(logic [39:0] data, logic user);
         result_type want;
         if (profile_q.size() == 0) begin
            report("result with nothing pending", data[31:0], 0);
            return;
         end
         want = profile_q.pop_front();
         if (user !== want.recognized) report("recognized", user, want.recognized);
         if (data[0] !== want.sixel_support) report("sixel_support", data[0], want.sixel_support);
         if (data[1] !== want.image_ack_support)
            report("image_ack_support", data[1], want.image_ack_support);
         if (data[2] !== want.placeholder_support)
            report("placeholder_support", data[2], want.placeholder_support);
         if (data[18:3] !== want.cell_width_px)
            report("cell_width_px", data[18:3], want.cell_width_px);
         if (data[34:19] !== want.cell_height_px)
            report("cell_height_px", data[34:19], want.cell_height_px);
         if (data[39:35] !== 5'd0) report("tdata pad bits", data[39:35], 0);
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   profile_board board;
   logic [7:0]   pay_q[$];
   int           bytes_sent    = 0;
   int           send_idle_pct = 12;
   int           recv_idle_pct = 82;

   terminal_reply_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: check on handshake, then pick next ready
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_byte(b, last);
   endtask

   task automatic send_payload();
      foreach (pay_q[i]) send_byte(pay_q[i], i == pay_q.size() - 1);
      bytes_sent += pay_q.size();
      pay_q.delete();
   endtask

   task automatic add_digits(input int unsigned v);
      logic [7:0] digs[$];
      do begin
         digs.push_front(CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digs[i]) pay_q.push_back(digs[i]);
   endtask

   task automatic add_number();
      int unsigned v;
      case ($urandom_range(5))
         0: v = $urandom_range(9);
         1: begin
            case ($urandom_range(4))
               0: v = 0;
               1: v = SIXEL_ATTR;
               2: v = ACK_IMAGE_ID;
               3: v = MIN_MINOR;
               default: v = MIN_MINOR - 1;
            endcase
         end
         2: v = $urandom_range(99);
         3: v = $urandom_range(65535);
         4: v = $urandom_range(65545, 65530);
         default: v = $urandom;
      endcase
      if ($urandom_range(7) == 0) pay_q.push_back(CH_ZERO);
      add_digits(v);
   endtask

   task automatic add_junk(input int n);
      repeat (n) pay_q.push_back(8'($urandom_range(255)));
   endtask

   task automatic add_tag();
      pay_q.push_back(CH_GREATER);
      for (int i = 0; i < 6; i++) pay_q.push_back(ver_tag_byte(3'(i)));
   endtask

   task automatic build_random_payload();
      int mode;
      int nf;
      int cut;
      mode = $urandom_range(99);
      if (mode < 8) begin
         add_junk($urandom_range(6, 1));
         return;
      end
      case ($urandom_range(3))
         0: begin
            pay_q.push_back(CH_LBRACKET);
            pay_q.push_back(CH_QUERY);
            nf = $urandom_range(4, 1);
            for (int f = 0; f < nf; f++) begin
               if (f > 0) pay_q.push_back(CH_SEMI);
               case ($urandom_range(9))
                  0: ;  // empty field
                  1: begin
                     pay_q.push_back(8'($urandom_range(8'h7E, 8'h40)));
                     if ($urandom_range(1)) add_number();
                  end
                  default: add_number();
               endcase
            end
            pay_q.push_back(CH_LOWER_C);
            if ($urandom_range(3) == 0) add_junk($urandom_range(3, 1));
         end
         1: begin
            pay_q.push_back(CH_LBRACKET);
            pay_q.push_back(CH_SIX);
            pay_q.push_back(CH_SEMI);
            add_number();
            pay_q.push_back(CH_SEMI);
            add_number();
            pay_q.push_back(CH_LOWER_T);
            if ($urandom_range(3) == 0) add_junk($urandom_range(3, 1));
         end
         2: begin
            pay_q.push_back(CH_UPPER_G);
            pay_q.push_back(CH_LOWER_I);
            pay_q.push_back(CH_EQUAL);
            if ($urandom_range(1)) add_digits(ACK_IMAGE_ID);
            else add_number();
            if ($urandom_range(3) != 0) pay_q.push_back(CH_SEMI);
            else add_junk(1);
            if ($urandom_range(1)) add_junk($urandom_range(3, 1));
         end
         default: begin
            add_tag();
            case ($urandom_range(2))
               0: ;
               1: pay_q.push_back(CH_LPAREN);
               default: pay_q.push_back(CH_SPACE);
            endcase
            case ($urandom_range(3))
               0, 1: add_digits(0);
               2: add_digits($urandom_range(9, 1));
               default: add_number();
            endcase
            pay_q.push_back(CH_DOT);
            if ($urandom_range(1)) add_digits($urandom_range(MIN_MINOR + 1, MIN_MINOR - 2));
            else add_number();
            if ($urandom_range(1)) add_junk(1);
         end
      endcase
      // broken sequences: cut short or one byte corrupted
      if (mode >= 84) begin
         if ($urandom_range(1)) begin
            cut = $urandom_range(pay_q.size(), 1);
            while (pay_q.size() > cut) void'(pay_q.pop_back());
         end else begin
            pay_q[$urandom_range(pay_q.size() - 1)] = 8'($urandom_range(255));
         end
      end
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: unknown prefixes at both byte extremes, then each reply kind
      pay_q.push_back(8'hFF);
      send_payload();
      pay_q.push_back(8'h00);
      send_payload();
      pay_q = '{CH_LBRACKET, CH_SIX, CH_SEMI};
      add_digits(9);
      pay_q.push_back(CH_SEMI);
      add_digits(8);
      pay_q.push_back(CH_LOWER_T);
      send_payload();
      pay_q = '{CH_LBRACKET, CH_QUERY};
      add_digits(SIXEL_ATTR);
      pay_q.push_back(CH_LOWER_C);
      send_payload();
      pay_q = '{CH_UPPER_G, CH_LOWER_I, CH_EQUAL};
      add_digits(ACK_IMAGE_ID);
      pay_q.push_back(CH_SEMI);
      send_payload();
      add_tag();
      add_digits(0);
      pay_q.push_back(CH_DOT);
      add_digits(MIN_MINOR);
      send_payload();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 82;
            end
            1: begin
               send_idle_pct = 82;
               recv_idle_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (bytes_sent < 30 + (ph + 1) * 183) begin
            build_random_payload();
            send_payload();
         end
      end
      req_tvalid <= 1'b0;

      while (board.profile_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
sv/trd_pkg.sv
sv/trd_parser.sv
sv/terminal_reply_decoder.sv
bench/tb_terminal_reply_decoder.sv
